// File: sv/rpsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpsf_pkg;

	localparam int AXES = 3;
	localparam int NORM_W = 32;
	localparam int NORM_LIMIT_LOG = 30;
	localparam int SHIFT_W = 5;
	localparam int SQ_W = 64;
	localparam int ROOT_W = 32;
	localparam int RR_W = ROOT_W + 1;
	localparam int ANG_W = 32;
	localparam int ANG_OUT_W = 16;
	localparam int TAB_LEN = 24;
	localparam int VEL_W = 16;
	localparam int DOP_W = 16;
	localparam int DIR_W = 16;
	localparam int DIR_FRAC = 14;
	localparam int QUOT_W = DIR_FRAC + 1;
	localparam int DIV_W = NORM_W + DIR_FRAC + 1;
	localparam int RANGE_W = 20;
	localparam int RES_W = 34;
	localparam int CORDIC_XW = 36;

	localparam logic [RANGE_W-1:0] RANGE_MAX = '1;
	localparam logic [ANG_W-1:0] ANG_HALF_TURN = 32'h8000_0000;
	localparam logic [ANG_W-1:0] ANG_ROUND = 32'h0000_8000;
	localparam logic [VEL_W-1:0] THRESH_RESET = 16'd128;

	typedef enum logic [1:0] {
		CFG_EGO_VEL_X,
		CFG_EGO_VEL_Y,
		CFG_EGO_VEL_Z,
		CFG_STATIC_THRESHOLD
	} cfg_idx_t;

	// arctangent of 2^-i, 2^32 units per turn
	function automatic logic [ANG_W-1:0] atan_step(input int i);
		logic [ANG_W-1:0] a;
		case (i)
			0: a = 32'd536870912;
			1: a = 32'd316933406;
			2: a = 32'd167458907;
			3: a = 32'd85004756;
			4: a = 32'd42667331;
			5: a = 32'd21354465;
			6: a = 32'd10679838;
			7: a = 32'd5340245;
			8: a = 32'd2670163;
			9: a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// File: sv/rpsf_point_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rpsf_point_if import rpsf_pkg::*; #(
	parameter int COORD_WIDTH = 20
) ();
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic signed [DOP_W-1:0] doppler;

	modport source (output valid, output pos_x, output pos_y, output pos_z, output doppler,
		input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, input doppler,
		output ready);
endinterface

`default_nettype wire

// File: sv/rpsf_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rpsf_result_if import rpsf_pkg::*; ();
	logic valid;
	logic ready;
	logic [RANGE_W-1:0] range_m;
	logic signed [ANG_OUT_W-1:0] azimuth;
	logic signed [ANG_OUT_W-1:0] elevation;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic signed [DIR_W-1:0] dir_z;
	logic is_static;

	modport source (output valid, output range_m, output azimuth, output elevation,
		output dir_x, output dir_y, output dir_z, output is_static, input ready);
	modport sink (input valid, input range_m, input azimuth, input elevation,
		input dir_x, input dir_y, input dir_z, input is_static, output ready);
endinterface

`default_nettype wire

// File: sv/rpsf_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module rpsf_sqrt import rpsf_pkg::*; #(
	parameter int DW = 64,
	parameter int LANES = 3,
	parameter int SBW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [LANES-1:0][DW-1:0] in_val,
	input  logic [SBW-1:0] in_sb,
	output logic out_vld,
	output logic [LANES-1:0][DW/2-1:0] out_root,
	output logic [LANES-1:0][DW/2:0] out_rem,
	output logic [SBW-1:0] out_sb
);

	localparam int NS = DW / 2;
	localparam logic [DW-1:0] ONE = {{(DW-1){1'b0}}, 1'b1};

	logic [NS-1:0] vld_s;
	logic [LANES-1:0][DW-1:0] rem_s [NS];
	logic [LANES-1:0][DW-1:0] root_s [NS];
	logic [LANES-1:0][DW-1:0] rem_nx [NS];
	logic [LANES-1:0][DW-1:0] root_nx [NS];
	logic [SBW-1:0] sb_s [NS];

	// one result bit per stage
	always_comb begin : c_step
		logic [DW-1:0] bit_w;
		logic [DW-1:0] rem_i;
		logic [DW-1:0] root_i;
		for (int k = 0; k < NS; k++) begin
			bit_w = ONE << (DW - 2 - 2 * k);
			for (int l = 0; l < LANES; l++) begin
				if (k == 0) begin
					rem_i = in_val[l];
					root_i = '0;
				end else begin
					rem_i = rem_s[k-1][l];
					root_i = root_s[k-1][l];
				end
				if ({1'b0, rem_i} >= ({1'b0, root_i} + {1'b0, bit_w})) begin
					rem_nx[k][l] = rem_i - root_i - bit_w;
					root_nx[k][l] = (root_i >> 1) + bit_w;
				end else begin
					rem_nx[k][l] = rem_i;
					root_nx[k][l] = root_i >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				rem_s[k] <= rem_nx[k];
				root_s[k] <= root_nx[k];
				sb_s[k] <= (k == 0) ? in_sb : sb_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_root[l] = root_s[NS-1][l][DW/2-1:0];
			out_rem[l] = rem_s[NS-1][l][DW/2:0];
		end
	end

	assign out_vld = vld_s[NS-1];
	assign out_sb = sb_s[NS-1];

endmodule

`default_nettype wire

// File: sv/rpsf_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module rpsf_cordic import rpsf_pkg::*; #(
	parameter int STEPS = 16,
	parameter int LANES = 2,
	parameter int XW = 36,
	parameter int SBW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [LANES-1:0][XW-1:0] in_x,
	input  logic [LANES-1:0][XW-1:0] in_y,
	input  logic [LANES-1:0][ANG_W-1:0] in_ang,
	input  logic [SBW-1:0] in_sb,
	output logic out_vld,
	output logic [LANES-1:0][ANG_W-1:0] out_ang,
	output logic [SBW-1:0] out_sb
);

	localparam int NS = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

	logic [NS-1:0] vld_s;
	logic [LANES-1:0][XW-1:0] x_s [NS];
	logic [LANES-1:0][XW-1:0] y_s [NS];
	logic [LANES-1:0][ANG_W-1:0] ang_s [NS];
	logic [LANES-1:0][XW-1:0] x_nx [NS];
	logic [LANES-1:0][XW-1:0] y_nx [NS];
	logic [LANES-1:0][ANG_W-1:0] ang_nx [NS];
	logic [SBW-1:0] sb_s [NS];

	// vectoring mode, one micro-rotation per stage
	always_comb begin : c_step
		logic signed [XW-1:0] xi;
		logic signed [XW-1:0] yi;
		logic [ANG_W-1:0] ai;
		for (int k = 0; k < NS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				if (k == 0) begin
					xi = $signed(in_x[l]);
					yi = $signed(in_y[l]);
					ai = in_ang[l];
				end else begin
					xi = $signed(x_s[k-1][l]);
					yi = $signed(y_s[k-1][l]);
					ai = ang_s[k-1][l];
				end
				if (yi > 0) begin
					x_nx[k][l] = xi + (yi >>> k);
					y_nx[k][l] = yi - (xi >>> k);
					ang_nx[k][l] = ai + atan_step(k);
				end else begin
					x_nx[k][l] = xi - (yi >>> k);
					y_nx[k][l] = yi + (xi >>> k);
					ang_nx[k][l] = ai - atan_step(k);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				x_s[k] <= x_nx[k];
				y_s[k] <= y_nx[k];
				ang_s[k] <= ang_nx[k];
				sb_s[k] <= (k == 0) ? in_sb : sb_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_ang[l] = ang_s[NS-1][l];
		end
	end

	assign out_vld = vld_s[NS-1];
	assign out_sb = sb_s[NS-1];

endmodule

`default_nettype wire

// File: sv/radar_point_polar_static_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// throughput: one point per cycle while results are taken, set by the fully pipelined
// square roots, divider and cordic; a stall on the result side holds every stage in place
// reset: asynchronous, clears all valid bits; ego velocity resets to 0, threshold to 128

module radar_point_polar_static_filter_top import rpsf_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_WIDTH = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  cfg_idx_t cfg_idx,
	input  logic [VEL_W-1:0] cfg_data,
	rpsf_point_if.sink point,
	rpsf_result_if.source result
);

	localparam int CW = COORD_WIDTH;
	localparam int SW = 2 * CW;

	typedef struct packed {
		logic nzr;
		logic sx;
		logic sy;
		logic sz;
		logic [DOP_W-1:0] dop;
		logic [NORM_W-1:0] nx;
		logic [NORM_W-1:0] ny;
		logic [NORM_W-1:0] nz;
	} sq_sb_t;

	typedef struct packed {
		logic nzr;
		logic sx;
		logic sy;
		logic sz;
		logic [DOP_W-1:0] dop;
		logic [RANGE_W-1:0] range_m;
		logic [ROOT_W-1:0] rn;
		logic [CORDIC_XW-1:0] cx_az;
		logic [CORDIC_XW-1:0] cy_az;
		logic [CORDIC_XW-1:0] cx_el;
		logic [CORDIC_XW-1:0] cy_el;
	} dv_c_t;

	typedef struct packed {
		logic nzr;
		logic [DOP_W-1:0] dop;
		logic [RANGE_W-1:0] range_m;
		logic [DIR_W-1:0] dx;
		logic [DIR_W-1:0] dy;
		logic [DIR_W-1:0] dz;
	} cd_sb_t;

	logic en;

	logic signed [VEL_W-1:0] ego_x_q;
	logic signed [VEL_W-1:0] ego_y_q;
	logic signed [VEL_W-1:0] ego_z_q;
	logic [VEL_W-1:0] thr_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10;
	logic [QUOT_W-1:0] dv_vld_s;

	logic [CW-1:0] x_s1, y_s1, z_s1;
	logic [DOP_W-1:0] dop_s1;

	logic [CW-1:0] ax_s2, ay_s2, az_s2;
	logic sx_s2, sy_s2, sz_s2;
	logic [DOP_W-1:0] dop_s2;

	logic [CW-1:0] mxy_2, m_2;
	logic [SW-1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [CW-1:0] ax_s3, ay_s3, az_s3, m_s3;
	logic sx_s3, sy_s3, sz_s3;
	logic [DOP_W-1:0] dop_s3;

	logic [NORM_W-1:0] mm_3;
	logic [SHIFT_W-1:0] sh_3;
	logic [SW-1:0] s_s4;
	logic [NORM_W-1:0] nx_s4, ny_s4, nz_s4;
	logic nzr_s4, sx_s4, sy_s4, sz_s4;
	logic [DOP_W-1:0] dop_s4;

	logic [SQ_W-1:0] s_s5, nsqx_s5, nsqy_s5, nsqz_s5;
	logic [NORM_W-1:0] nx_s5, ny_s5, nz_s5;
	logic nzr_s5, sx_s5, sy_s5, sz_s5;
	logic [DOP_W-1:0] dop_s5;

	logic [AXES-1:0][SQ_W-1:0] sq_in_s6;
	sq_sb_t sb_s6;

	logic sq_vld;
	logic [AXES-1:0][ROOT_W-1:0] sq_root;
	logic [AXES-1:0][ROOT_W:0] sq_rem;
	sq_sb_t sq_sb;

	logic [RR_W-1:0] rr_6;
	dv_c_t c7_nx;
	dv_c_t c_s7;
	logic [AXES-1:0][DIV_W-1:0] dvd_s7;

	logic [AXES-1:0][DIV_W-1:0] dv_rem_s [QUOT_W];
	logic [AXES-1:0][DIV_W-1:0] dv_rem_nx [QUOT_W];
	logic [AXES-1:0][QUOT_W-1:0] dv_q_s [QUOT_W];
	logic [AXES-1:0][QUOT_W-1:0] dv_q_nx [QUOT_W];
	dv_c_t dv_c_s [QUOT_W];

	dv_c_t dv_last;
	logic [AXES-1:0] dir_sgn;
	logic [AXES-1:0][DIR_W-1:0] dir_v;
	cd_sb_t cd_in_sb;
	logic [1:0][CORDIC_XW-1:0] cd_x, cd_y;
	logic [1:0][ANG_W-1:0] cd_ang0;

	logic cd_vld;
	logic [1:0][ANG_W-1:0] cd_ang;
	cd_sb_t cd_sb;
	logic [ANG_W-1:0] azr_8, elr_8;

	logic signed [2*VEL_W-1:0] px_s8, py_s8, pz_s8;
	logic [ANG_OUT_W-1:0] azi_s8, ele_s8;
	cd_sb_t c_s8;

	logic [RES_W-1:0] res_s9;
	logic [ANG_OUT_W-1:0] azi_s9, ele_s9;
	cd_sb_t c_s9;

	logic [RES_W-1:0] ares_9;
	logic [ANG_OUT_W-1:0] azi_s10, ele_s10;
	cd_sb_t c_s10;
	logic stat_s10;

	assign en = !vld_s10 || result.ready;
	assign point.ready = en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ego_x_q <= '0;
			ego_y_q <= '0;
			ego_z_q <= '0;
			thr_q <= THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_EGO_VEL_X: ego_x_q <= cfg_data;
				CFG_EGO_VEL_Y: ego_y_q <= cfg_data;
				CFG_EGO_VEL_Z: ego_z_q <= cfg_data;
				CFG_STATIC_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			dv_vld_s <= '0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= sq_vld;
			dv_vld_s <= {dv_vld_s[QUOT_W-2:0], vld_s7};
			vld_s8 <= cd_vld;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// front end: magnitudes, squares, normalization
	assign mxy_2 = (ax_s2 > ay_s2) ? ax_s2 : ay_s2;
	assign m_2 = (mxy_2 > az_s2) ? mxy_2 : az_s2;

	always_comb begin
		mm_3 = NORM_W'(m_s3);
		sh_3 = '0;
		for (int i = SHIFT_W - 1; i >= 0; i--) begin
			if (mm_3 < (NORM_W'(1) << (NORM_LIMIT_LOG - (1 << i)))) begin
				mm_3 = mm_3 << (1 << i);
				sh_3[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= point.pos_x;
			y_s1 <= point.pos_y;
			z_s1 <= point.pos_z;
			dop_s1 <= point.doppler;

			ax_s2 <= x_s1[CW-1] ? -x_s1 : x_s1;
			ay_s2 <= y_s1[CW-1] ? -y_s1 : y_s1;
			az_s2 <= z_s1[CW-1] ? -z_s1 : z_s1;
			sx_s2 <= x_s1[CW-1];
			sy_s2 <= y_s1[CW-1];
			sz_s2 <= z_s1[CW-1];
			dop_s2 <= dop_s1;

			sqx_s3 <= ax_s2 * ax_s2;
			sqy_s3 <= ay_s2 * ay_s2;
			sqz_s3 <= az_s2 * az_s2;
			m_s3 <= m_2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			az_s3 <= az_s2;
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			sz_s3 <= sz_s2;
			dop_s3 <= dop_s2;

			s_s4 <= sqx_s3 + sqy_s3 + sqz_s3;
			nx_s4 <= NORM_W'(ax_s3) << sh_3;
			ny_s4 <= NORM_W'(ay_s3) << sh_3;
			nz_s4 <= NORM_W'(az_s3) << sh_3;
			nzr_s4 <= (m_s3 != '0);
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
			sz_s4 <= sz_s3;
			dop_s4 <= dop_s3;

			s_s5 <= SQ_W'(s_s4);
			nsqx_s5 <= nx_s4 * nx_s4;
			nsqy_s5 <= ny_s4 * ny_s4;
			nsqz_s5 <= nz_s4 * nz_s4;
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
			nz_s5 <= nz_s4;
			nzr_s5 <= nzr_s4;
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
			sz_s5 <= sz_s4;
			dop_s5 <= dop_s4;

			sq_in_s6[0] <= s_s5;
			sq_in_s6[1] <= nsqx_s5 + nsqy_s5 + nsqz_s5;
			sq_in_s6[2] <= nsqx_s5 + nsqy_s5;
			sb_s6.nzr <= nzr_s5;
			sb_s6.sx <= sx_s5;
			sb_s6.sy <= sy_s5;
			sb_s6.sz <= sz_s5;
			sb_s6.dop <= dop_s5;
			sb_s6.nx <= nx_s5;
			sb_s6.ny <= ny_s5;
			sb_s6.nz <= nz_s5;
		end
	end

	// lane 0: range, lane 1: normalized norm, lane 2: normalized horizontal
	rpsf_sqrt #(
		.DW(SQ_W),
		.LANES(AXES),
		.SBW($bits(sq_sb_t))
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s6),
		.in_val(sq_in_s6),
		.in_sb(sb_s6),
		.out_vld(sq_vld),
		.out_root(sq_root),
		.out_rem(sq_rem),
		.out_sb(sq_sb)
	);

	assign rr_6 = {1'b0, sq_root[0]} + RR_W'(sq_rem[0] > {1'b0, sq_root[0]});

	always_comb begin
		c7_nx.nzr = sq_sb.nzr;
		c7_nx.sx = sq_sb.sx;
		c7_nx.sy = sq_sb.sy;
		c7_nx.sz = sq_sb.sz;
		c7_nx.dop = sq_sb.dop;
		c7_nx.range_m = (rr_6 > RR_W'(RANGE_MAX)) ? RANGE_MAX : rr_6[RANGE_W-1:0];
		c7_nx.rn = sq_root[1];
		c7_nx.cx_az = CORDIC_XW'(sq_sb.nx);
		c7_nx.cy_az = (sq_sb.sx ^ sq_sb.sy) ? -CORDIC_XW'(sq_sb.ny) : CORDIC_XW'(sq_sb.ny);
		c7_nx.cx_el = CORDIC_XW'(sq_root[2]);
		c7_nx.cy_el = sq_sb.sz ? -CORDIC_XW'(sq_sb.nz) : CORDIC_XW'(sq_sb.nz);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s7 <= c7_nx;
			dvd_s7[0] <= DIV_W'({sq_sb.nx, {DIR_FRAC{1'b0}}}) + DIV_W'(sq_root[1] >> 1);
			dvd_s7[1] <= DIV_W'({sq_sb.ny, {DIR_FRAC{1'b0}}}) + DIV_W'(sq_root[1] >> 1);
			dvd_s7[2] <= DIV_W'({sq_sb.nz, {DIR_FRAC{1'b0}}}) + DIV_W'(sq_root[1] >> 1);
		end
	end

	// restoring divider, one quotient bit per stage
	always_comb begin : c_div
		logic [DIV_W-1:0] rem_i;
		logic [DIV_W-1:0] sub_i;
		logic [QUOT_W-1:0] q_i;
		logic [ROOT_W-1:0] rn_i;
		for (int k = 0; k < QUOT_W; k++) begin
			if (k == 0) begin
				rn_i = c_s7.rn;
			end else begin
				rn_i = dv_c_s[k-1].rn;
			end
			sub_i = DIV_W'(rn_i) << (QUOT_W - 1 - k);
			for (int l = 0; l < AXES; l++) begin
				if (k == 0) begin
					rem_i = dvd_s7[l];
					q_i = '0;
				end else begin
					rem_i = dv_rem_s[k-1][l];
					q_i = dv_q_s[k-1][l];
				end
				if (rem_i >= sub_i) begin
					dv_rem_nx[k][l] = rem_i - sub_i;
					q_i[QUOT_W-1-k] = 1'b1;
				end else begin
					dv_rem_nx[k][l] = rem_i;
				end
				dv_q_nx[k][l] = q_i;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUOT_W; k++) begin
				dv_rem_s[k] <= dv_rem_nx[k];
				dv_q_s[k] <= dv_q_nx[k];
				dv_c_s[k] <= (k == 0) ? c_s7 : dv_c_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign dv_last = dv_c_s[QUOT_W-1];
	assign dir_sgn = {dv_last.sz, dv_last.sy, dv_last.sx};

	always_comb begin
		for (int l = 0; l < AXES; l++) begin
			if (!dv_last.nzr) begin
				dir_v[l] = '0;
			end else if (dir_sgn[l]) begin
				dir_v[l] = -DIR_W'(dv_q_s[QUOT_W-1][l]);
			end else begin
				dir_v[l] = DIR_W'(dv_q_s[QUOT_W-1][l]);
			end
		end
		cd_in_sb.nzr = dv_last.nzr;
		cd_in_sb.dop = dv_last.dop;
		cd_in_sb.range_m = dv_last.range_m;
		cd_in_sb.dx = dir_v[0];
		cd_in_sb.dy = dir_v[1];
		cd_in_sb.dz = dir_v[2];
		cd_x[0] = dv_last.cx_az;
		cd_y[0] = dv_last.cy_az;
		cd_ang0[0] = dv_last.sx ? ANG_HALF_TURN : '0;
		cd_x[1] = dv_last.cx_el;
		cd_y[1] = dv_last.cy_el;
		cd_ang0[1] = '0;
	end

	// lane 0: azimuth, lane 1: elevation
	rpsf_cordic #(
		.STEPS(CORDIC_STEPS),
		.LANES(2),
		.XW(CORDIC_XW),
		.SBW($bits(cd_sb_t))
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(dv_vld_s[QUOT_W-1]),
		.in_x(cd_x),
		.in_y(cd_y),
		.in_ang(cd_ang0),
		.in_sb(cd_in_sb),
		.out_vld(cd_vld),
		.out_ang(cd_ang),
		.out_sb(cd_sb)
	);

	assign azr_8 = cd_ang[0] + ANG_ROUND;
	assign elr_8 = cd_ang[1] + ANG_ROUND;
	assign ares_9 = res_s9[RES_W-1] ? -res_s9 : res_s9;

	// back end: residual against ego motion
	always_ff @(posedge clk) begin
		if (en) begin
			px_s8 <= $signed(ego_x_q) * $signed(cd_sb.dx);
			py_s8 <= $signed(ego_y_q) * $signed(cd_sb.dy);
			pz_s8 <= $signed(ego_z_q) * $signed(cd_sb.dz);
			azi_s8 <= cd_sb.nzr ? azr_8[ANG_W-1 -: ANG_OUT_W] : '0;
			ele_s8 <= cd_sb.nzr ? elr_8[ANG_W-1 -: ANG_OUT_W] : '0;
			c_s8 <= cd_sb;

			res_s9 <= {{(RES_W - DOP_W - DIR_FRAC){c_s8.dop[DOP_W-1]}}, c_s8.dop,
				{DIR_FRAC{1'b0}}} + RES_W'(px_s8) + RES_W'(py_s8) + RES_W'(pz_s8);
			azi_s9 <= azi_s8;
			ele_s9 <= ele_s8;
			c_s9 <= c_s8;

			stat_s10 <= ares_9 < RES_W'({thr_q, {DIR_FRAC{1'b0}}});
			azi_s10 <= azi_s9;
			ele_s10 <= ele_s9;
			c_s10 <= c_s9;
		end
	end

	assign result.valid = vld_s10;
	assign result.range_m = c_s10.range_m;
	assign result.azimuth = azi_s10;
	assign result.elevation = ele_s10;
	assign result.dir_x = c_s10.dx;
	assign result.dir_y = c_s10.dy;
	assign result.dir_z = c_s10.dz;
	assign result.is_static = stat_s10;

endmodule

`default_nettype wire
